FILE: hdl/bip_pkg.sv
// bip_pkg: shared widths, codes, types and helpers of the bitmap index pager
// used by bip_front, bip_back, bitmap_index_pager_unit and bip_checker
// no dependencies
package bip_pkg;

   // field and register widths
   localparam int WORD_W      = 64;
   localparam int OFF_W       = 6;
   localparam int WORDS_W     = 17;
   localparam int START_W     = 22;
   localparam int LIMIT_W     = 17;
   localparam int POS_W       = 22;
   localparam int NEXT_W      = 24;
   localparam int COUNT_W     = 17;
   localparam int WIDX_W      = START_W - OFF_W;

   // stream and csr port widths
   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 22;

   // parameter defaults
   localparam int unsigned MAX_WORDS_DEFAULT = 65536;
   localparam int unsigned MAX_PAGE_DEFAULT  = 65536;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_WORDS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_INDEX  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAGE_LIMIT   = 2'd2;

   // register reset values
   localparam logic [WORDS_W-1:0] VECTOR_WORDS_RESET = 17'd1;
   localparam logic [START_W-1:0] START_INDEX_RESET  = 22'd0;
   localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET   = 17'd1;

   // queue between front and back
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = 1;
   localparam int QCOUNT_W = 2;

   // word classes decided by the front
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_CONT     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRST    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAST_END = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ZERO_LIM = 2'd3;

   // live configuration, already saturated
   typedef struct packed {
      logic [WORDS_W-1:0] words;
      logic [LIMIT_W-1:0] limit;
      logic [START_W-1:0] start_index;
   } cfg_type;

   // one queued word with its class
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] word;
   } entry_type;

   // one result beat
   typedef struct packed {
      logic                     match_valid;
      logic [POS_W-1:0]         match_position;
      logic                     run_end;
      logic                     page_end;
      logic signed [NEXT_W-1:0] next_start;
      logic [COUNT_W-1:0]       found_count;
   } rsp_type;

   // offset of the lowest set bit (zero for an empty word)
   function automatic logic [OFF_W-1:0] lowest_set_offset(input logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] iso;
      logic [OFF_W-1:0]  off;
      iso = w & (~w + {{(WORD_W-1){1'b0}}, 1'b1});
      off = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (iso[i]) begin
            off = off | OFF_W'(i);
         end
      end
      return off;
   endfunction

endpackage

FILE: hdl/bitmap_index_pager_unit.sv
// bitmap_index_pager_unit: top level of the bitmap index pager, holds the
// configuration registers and joins bip_front and bip_back; depends on bip_pkg
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata word_bits, tuser first_word
//   rsp      out  rsp_tvalid/rsp_tready  tdata position/next/count, tuser flags,
//                                        tlast run_end
//   csr      in   csr_we                 csr_index, csr_wdata
//
// a word leaves the queue when the back end is idle and the result register is
// free, then the back end's set-bit walk yields one result per set bit (up to 64
// for a dense word); a walked word that yields nothing takes one step in the walk
// a two-entry queue and the result register let either side stall on its own
// synchronous reset empties the queue and the result register, ends the open page
module bitmap_index_pager_unit #(
   parameter int unsigned MAX_WORDS = bip_pkg::MAX_WORDS_DEFAULT,
   parameter int unsigned MAX_PAGE  = bip_pkg::MAX_PAGE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // word_bits[63:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bip_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // first_word[0]
   input  logic [bip_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // match_position[21:0], next_start[45:22], found_count[62:46], zero[63]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bip_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // match_valid[0], page_end[1]
   output logic [bip_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [bip_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bip_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [bip_pkg::WORDS_W-1:0]  vector_words_ff, vector_words_in;
   logic [bip_pkg::START_W-1:0]  start_index_ff, start_index_in;
   logic [bip_pkg::LIMIT_W-1:0]  page_limit_ff, page_limit_in;
   bip_pkg::cfg_type             cfg;
   logic                         q_valid;
   logic                         q_pop;
   bip_pkg::entry_type           q_entry;
   bip_pkg::rsp_type             rsp_data;

   // configuration writes
   always_comb begin
      vector_words_in = vector_words_ff;
      start_index_in  = start_index_ff;
      page_limit_in   = page_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            bip_pkg::CSR_VECTOR_WORDS: vector_words_in = csr_wdata[bip_pkg::WORDS_W-1:0];
            bip_pkg::CSR_START_INDEX:  start_index_in  = csr_wdata[bip_pkg::START_W-1:0];
            bip_pkg::CSR_PAGE_LIMIT:   page_limit_in   = csr_wdata[bip_pkg::LIMIT_W-1:0];
            default:                   vector_words_in = vector_words_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_words_ff <= bip_pkg::VECTOR_WORDS_RESET;
         start_index_ff  <= bip_pkg::START_INDEX_RESET;
         page_limit_ff   <= bip_pkg::PAGE_LIMIT_RESET;
      end else begin
         vector_words_ff <= vector_words_in;
         start_index_ff  <= start_index_in;
         page_limit_ff   <= page_limit_in;
      end
   end

   // saturate word count and page limit
   always_comb begin
      cfg.words       = (32'(vector_words_ff) > MAX_WORDS) ?
                        MAX_WORDS[bip_pkg::WORDS_W-1:0] : vector_words_ff;
      cfg.limit       = (32'(page_limit_ff) > MAX_PAGE) ?
                        MAX_PAGE[bip_pkg::LIMIT_W-1:0] : page_limit_ff;
      cfg.start_index = start_index_ff;
   end

   bip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   bip_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   // pack the result beat
   assign rsp_tdata = {1'b0, rsp_data.found_count, rsp_data.next_start,
                       rsp_data.match_position};
   assign rsp_tuser = {rsp_data.page_end, rsp_data.match_valid};
   assign rsp_tlast = rsp_data.run_end;

endmodule

FILE: hdl/bip_front.sv
// bip_front: accepts bitmap words, classifies them and masks first words, and holds them
// in a two-entry queue for the back end; depends on bip_pkg
module bip_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bip_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [bip_pkg::REQ_TUSER_W-1:0]     req_tuser,
   input  bip_pkg::cfg_type                    cfg,
   output logic                                q_valid,
   output bip_pkg::entry_type                  q_entry,
   input  logic                                q_pop
);

   bip_pkg::entry_type                  q_ff [bip_pkg::QDEPTH];
   logic [bip_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [bip_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [bip_pkg::QCOUNT_W-1:0]        count_ff, count_in;
   bip_pkg::entry_type                  new_entry;
   logic                                push;
   logic [bip_pkg::OFF_W-1:0]           start_off;
   logic [bip_pkg::WIDX_W-1:0]          start_widx;

   // classify the incoming beat
   assign start_off  = cfg.start_index[bip_pkg::OFF_W-1:0];
   assign start_widx = cfg.start_index[bip_pkg::START_W-1:bip_pkg::OFF_W];

   always_comb begin
      new_entry.word = req_tdata;
      new_entry.kind = bip_pkg::KIND_CONT;
      if (req_tuser[0]) begin
         new_entry.word = req_tdata & ({bip_pkg::WORD_W{1'b1}} << start_off);
         if ({1'b0, start_widx} >= cfg.words) begin
            new_entry.kind = bip_pkg::KIND_PAST_END;
         end else if (cfg.limit == '0) begin
            new_entry.kind = bip_pkg::KIND_ZERO_LIM;
         end else begin
            new_entry.kind = bip_pkg::KIND_FIRST;
         end
      end
   end

   // queue pointers and fill level
   assign req_tready = (count_ff != bip_pkg::QCOUNT_W'(bip_pkg::QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_entry    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: hdl/bip_back.sv
// bip_back: walks the set bits of queued words, one result beat per cycle while the result
// register is free, keeps the page state and the result register; depends on bip_pkg
module bip_back (
   input  logic                clock,
   input  logic                reset,
   input  bip_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  bip_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bip_pkg::rsp_type    rsp_data
);

   logic                          active_ff, active_in;
   logic                          busy_ff, busy_in;
   logic [bip_pkg::WORDS_W-1:0]   widx_ff, widx_in;
   logic [bip_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [bip_pkg::WORD_W-1:0]    work_ff, work_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bip_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          out_free;
   logic                          word_is_last;
   logic [bip_pkg::OFF_W-1:0]     off;
   logic [bip_pkg::WORD_W-1:0]    rest;
   logic [bip_pkg::COUNT_W-1:0]   cnt_next;
   logic [bip_pkg::NEXT_W-1:0]    pos_full;
   logic [bip_pkg::NEXT_W-1:0]    pos_plus;

   function automatic bip_pkg::rsp_type make_rsp(
      input logic                          valid,
      input logic [bip_pkg::POS_W-1:0]     pos,
      input logic                          rend,
      input logic                          pend,
      input logic [bip_pkg::NEXT_W-1:0]    next,
      input logic [bip_pkg::COUNT_W-1:0]   cnt
   );
      bip_pkg::rsp_type r;
      r.match_valid    = valid;
      r.match_position = pos;
      r.run_end        = rend;
      r.page_end       = pend;
      r.next_start     = next;
      r.found_count    = cnt;
      return r;
   endfunction

   // lowest set bit of the word in work and where the word sits
   assign off          = bip_pkg::lowest_set_offset(work_ff);
   assign rest         = work_ff & (work_ff - {{(bip_pkg::WORD_W-1){1'b0}}, 1'b1});
   assign cnt_next     = count_ff + 1'b1;
   assign pos_full     = {1'b0, widx_ff, off};
   assign pos_plus     = pos_full + 1'b1;
   assign word_is_last = ({1'b0, widx_ff} + 1'b1) >= {1'b0, cfg.words};
   assign out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      active_in    = active_ff;
      busy_in      = busy_ff;
      widx_in      = widx_ff;
      count_in     = count_ff;
      work_in      = work_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;

      if (busy_ff && out_free) begin
         // one set bit per cycle, or close out an empty word
         if (work_ff == '0) begin
            busy_in = 1'b0;
            if (word_is_last) begin
               active_in    = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(1'b0, '0, 1'b1, 1'b1, '1, count_ff);
            end else begin
               widx_in = widx_ff + 1'b1;
            end
         end else begin
            count_in     = cnt_next;
            rsp_valid_in = 1'b1;
            if (cnt_next >= cfg.limit) begin
               active_in = 1'b0;
               busy_in   = 1'b0;
               rsp_in    = make_rsp(1'b1, pos_full[bip_pkg::POS_W-1:0], 1'b1, 1'b1,
                                    pos_plus, cnt_next);
            end else if (rest == '0) begin
               busy_in = 1'b0;
               if (word_is_last) begin
                  active_in = 1'b0;
                  rsp_in    = make_rsp(1'b1, pos_full[bip_pkg::POS_W-1:0], 1'b1, 1'b1,
                                       '1, cnt_next);
               end else begin
                  widx_in = widx_ff + 1'b1;
                  rsp_in  = make_rsp(1'b1, pos_full[bip_pkg::POS_W-1:0], 1'b1, 1'b0,
                                     '0, cnt_next);
               end
            end else begin
               work_in = rest;
               rsp_in  = make_rsp(1'b1, pos_full[bip_pkg::POS_W-1:0], 1'b0, 1'b0,
                                  '0, cnt_next);
            end
         end
      end else if (!busy_ff && q_valid && out_free) begin
         // take the next word from the queue
         q_pop = 1'b1;
         unique case (q_entry.kind)
            bip_pkg::KIND_CONT: begin
               if (active_ff) begin
                  work_in = q_entry.word;
                  busy_in = 1'b1;
               end
            end
            bip_pkg::KIND_FIRST: begin
               widx_in   = {1'b0, cfg.start_index[bip_pkg::START_W-1:bip_pkg::OFF_W]};
               count_in  = '0;
               active_in = 1'b1;
               work_in   = q_entry.word;
               busy_in   = 1'b1;
            end
            bip_pkg::KIND_PAST_END: begin
               active_in    = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(1'b0, '0, 1'b1, 1'b1, '1, '0);
            end
            bip_pkg::KIND_ZERO_LIM: begin
               active_in    = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(1'b0, '0, 1'b1, 1'b1,
                                       {2'b00, cfg.start_index}, '0);
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // page payload and result register
   always_ff @(posedge clock) begin
      widx_ff  <= widx_in;
      count_ff <= count_in;
      work_ff  <= work_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/bip_checker.sv
// bip_checker: port-level checks on the bitmap index pager result stream,
// bound to bitmap_index_pager_unit; depends on bip_pkg
module bip_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tready,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [bip_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic [bip_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   input  logic                              rsp_tlast
);

   // reset empties the queue and the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("queue or result register not cleared by reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) &&
                                       $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result beat changed");

   // closing a page also ends the word's run
   a_page_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tlast)
      else $error("page end without run end");

   // a beat without a position is always a page close with zero position
   a_no_match_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tuser[1] && rsp_tlast &&
                                         rsp_tdata[21:0] == 22'd0))
      else $error("empty beat that does not close the page");

   // resume position is zero unless the page closes
   a_next_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[1]) |-> (rsp_tdata[45:22] == 24'd0))
      else $error("next start set on an open page");

endmodule

bind bitmap_index_pager_unit bip_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
